// ===== rtl/mcrf_pkg.sv =====
package mcrf_pkg;

  // Command codes of an input word
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_BYTE  = 1'b1;

  localparam logic [31:0] CRC_POLY     = 32'h82F6_3B78;
  localparam logic [31:0] CRC_ALL_ONES = 32'hFFFF_FFFF;
  localparam logic [31:0] CRC_MASK_ADD = 32'hA282_EAD8;
  localparam int unsigned CRC_ROT      = 15;

  // Job queue depth between front and back
  localparam int unsigned QUEUE_DEPTH = 4;

  // Sequence positions inside a job
  localparam logic [3:0] IDX_HDR_CRC  = 4'd8;
  localparam logic [3:0] IDX_HDR_LAST = 4'd11;
  localparam logic [3:0] IDX_FTR_LAST = 4'd4;
  localparam logic [3:0] IDX_ZERO_END = 4'd15;

  typedef struct packed {
    logic        command;
    logic [31:0] record_length;
    logic [7:0]  payload_byte;
  } cmd_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
    logic       record_end;
    logic       error;
  } res_word_t;

  typedef enum logic [2:0] {
    JOB_ERROR,
    JOB_BYTE,
    JOB_BYTE_LAST,
    JOB_START,
    JOB_START_ZERO
  } job_kind_t;

  typedef struct packed {
    job_kind_t   kind;
    logic [7:0]  data;
    logic [31:0] value;
  } job_t;

  // Reflected CRC32C update by one byte
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  // Finalize, rotate right and add the mask constant
  function automatic logic [31:0] mask_crc(input logic [31:0] crc_reg);
    logic [31:0] c;
    c = crc_reg ^ CRC_ALL_ONES;
    return ((c >> CRC_ROT) | (c << (32 - CRC_ROT))) + CRC_MASK_ADD;
  endfunction

  function automatic logic [7:0] byte_of(input logic [31:0] w, input logic [1:0] sel);
    return w[8*sel +: 8];
  endfunction

endpackage

// ===== rtl/masked_crc32c_record_framer_unit.sv =====
// The job is written into the queue at the edge that accepts its input word; the
// output register loads each result word from the queue head when it is free.
// Throughput: one input word per cycle while the job queue has room. The output
// sequencer emits one word per cycle unless the output stalls: a start gives 12
// words (16 for zero length), the last payload byte 5, any other byte or error 1.
// Reset (synchronous, active high) closes any record, empties the queue and output.
module masked_crc32c_record_framer_unit
  import mcrf_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH_P = QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      cmd_valid,
  output logic      cmd_stall,
  input  cmd_word_t cmd,
  output logic      res_valid,
  input  logic      res_stall,
  output res_word_t res
);

  logic q_full;
  logic q_nonempty;
  logic q_push;
  logic q_pop;
  job_t push_job;
  job_t head;

  assign cmd_stall = q_full;

  mcrf_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(cmd_valid),
    .cmd      (cmd),
    .q_full   (q_full),
    .push     (q_push),
    .push_job (push_job)
  );

  mcrf_queue #(
    .DEPTH(QUEUE_DEPTH_P)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .push_job(push_job),
    .pop     (q_pop),
    .full    (q_full),
    .nonempty(q_nonempty),
    .head    (head)
  );

  mcrf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_nonempty(q_nonempty),
    .head      (head),
    .pop       (q_pop),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

  // Never retire a job from an empty queue
  assert property (@(posedge clk) disable iff (rst) q_pop |-> q_nonempty)
    else $error("job popped from empty queue");

  // A record's final footer word closes its input's results and is no error
  assert property (@(posedge clk) disable iff (rst)
    res_valid && res.record_end |-> res.out_last && !res.error)
    else $error("record end word malformed");

  // An error word stands alone with a zero byte
  assert property (@(posedge clk) disable iff (rst)
    res_valid && res.error |-> res.out_last && res.out_byte == 8'd0 && !res.record_end)
    else $error("error word malformed");

  // A full queue holds the next word off
  assert property (@(posedge clk) disable iff (rst) q_full |-> cmd_stall && q_nonempty)
    else $error("queue full without stall");

endmodule

// ===== rtl/mcrf_front.sv =====
module mcrf_front
  import mcrf_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      cmd_valid,
  input  cmd_word_t cmd,
  input  logic      q_full,
  output logic      push,
  output job_t      push_job
);

  logic        record_open;
  logic [31:0] bytes_remaining;
  logic [31:0] payload_crc;

  logic        record_open_next;
  logic [31:0] bytes_remaining_next;
  logic [31:0] payload_crc_next;
  logic [31:0] crc_upd;

  assign push    = cmd_valid && !q_full;
  assign crc_upd = crc_byte(payload_crc, cmd.payload_byte);

  // Classify the word and work out the record state that follows it
  always_comb begin
    record_open_next     = record_open;
    bytes_remaining_next = bytes_remaining;
    payload_crc_next     = payload_crc;
    push_job.kind        = JOB_ERROR;
    push_job.data        = cmd.payload_byte;
    push_job.value       = cmd.record_length;
    if (cmd.command == CMD_START) begin
      if (!record_open) begin
        payload_crc_next = CRC_ALL_ONES;
        if (cmd.record_length == 32'd0) begin
          push_job.kind = JOB_START_ZERO;
        end else begin
          push_job.kind        = JOB_START;
          record_open_next     = 1'b1;
          bytes_remaining_next = cmd.record_length;
        end
      end
    end else if (record_open) begin
      if (bytes_remaining == 32'd1) begin
        push_job.kind        = JOB_BYTE_LAST;
        push_job.value       = crc_upd;
        record_open_next     = 1'b0;
        bytes_remaining_next = 32'd0;
        payload_crc_next     = CRC_ALL_ONES;
      end else begin
        push_job.kind        = JOB_BYTE;
        bytes_remaining_next = bytes_remaining - 32'd1;
        payload_crc_next     = crc_upd;
      end
    end
  end

  // Advance the record state on each accepted word
  always_ff @(posedge clk) begin
    if (rst) begin
      record_open     <= 1'b0;
      bytes_remaining <= 32'd0;
      payload_crc     <= CRC_ALL_ONES;
    end else if (push) begin
      record_open     <= record_open_next;
      bytes_remaining <= bytes_remaining_next;
      payload_crc     <= payload_crc_next;
    end
  end

endmodule

// ===== rtl/mcrf_queue.sv =====
module mcrf_queue
  import mcrf_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output logic full,
  output logic nonempty,
  output job_t head
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  job_t          slots [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full     = (count == CW'(DEPTH));
  assign nonempty = (count != '0);
  assign head     = slots[rd_ptr];

  // Store pushed jobs
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

// ===== rtl/mcrf_back.sv =====
module mcrf_back
  import mcrf_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      q_nonempty,
  input  job_t      head,
  output logic      pop,
  output logic      res_valid,
  input  logic      res_stall,
  output res_word_t res
);

  localparam logic [31:0] ZERO_FOOTER = mask_crc(CRC_ALL_ONES);

  logic [3:0]  idx;
  logic [31:0] hcrc;

  logic        emit;
  logic        job_done;
  res_word_t   word_next;
  logic [7:0]  hdr_byte;
  logic [31:0] hdr_mask;
  logic [31:0] ftr_mask;
  logic [3:0]  ftr_idx;

  assign emit     = q_nonempty && (!res_valid || !res_stall);
  assign pop      = emit && job_done;
  assign hdr_byte = idx[3:2] == 2'd0 ? byte_of(head.value, idx[1:0]) : 8'd0;
  assign hdr_mask = mask_crc(hcrc);
  assign ftr_mask = mask_crc(head.value);
  assign ftr_idx  = idx - 4'd1;

  // Build the next result word of the job at the queue head
  always_comb begin
    word_next = '0;
    job_done  = 1'b1;
    unique case (head.kind)
      JOB_ERROR: begin
        word_next.out_last = 1'b1;
        word_next.error    = 1'b1;
      end
      JOB_BYTE: begin
        word_next.out_byte = head.data;
        word_next.out_last = 1'b1;
      end
      JOB_BYTE_LAST: begin
        job_done             = (idx == IDX_FTR_LAST);
        word_next.out_byte   = (idx == 4'd0) ? head.data : byte_of(ftr_mask, ftr_idx[1:0]);
        word_next.out_last   = job_done;
        word_next.record_end = job_done;
      end
      JOB_START, JOB_START_ZERO: begin
        if (idx < IDX_HDR_CRC) begin
          word_next.out_byte = hdr_byte;
        end else if (idx <= IDX_HDR_LAST) begin
          word_next.out_byte = byte_of(hdr_mask, idx[1:0]);
        end else begin
          word_next.out_byte = byte_of(ZERO_FOOTER, idx[1:0]);
        end
        if (head.kind == JOB_START) begin
          job_done = (idx == IDX_HDR_LAST);
        end else begin
          job_done             = (idx == IDX_ZERO_END);
          word_next.record_end = job_done;
        end
        word_next.out_last = job_done;
      end
      default: begin
        word_next.out_last = 1'b1;
        word_next.error    = 1'b1;
      end
    endcase
  end

  // Step through the job and fold header bytes into the header CRC
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (emit) begin
      idx <= job_done ? 4'd0 : idx + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (emit && idx < IDX_HDR_CRC) begin
      hcrc <= crc_byte((idx == 4'd0) ? CRC_ALL_ONES : hcrc, hdr_byte);
    end
  end

  // Output register: load when empty or taken
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (!res_valid || !res_stall) begin
      res_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      res <= word_next;
    end
  end

endmodule
